### sv/tbg_pkg.sv
`default_nettype none

package tbg_pkg;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int LEN_W       = 24;
  localparam int RECIP_W     = 17;
  localparam int LEVEL_W     = 15;
  localparam int ENV_POS_W   = 32;
  localparam int SINE_X_W    = 31;
  localparam int SINE_SPAN   = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0]        RST_PHASE_STEP  = 32'd0;
  localparam logic [LEN_W-1:0]   RST_PRE_LEN     = 24'd0;
  localparam logic [LEN_W-1:0]   RST_BURST_LEN   = 24'd480;
  localparam logic [LEN_W-1:0]   RST_SILENCE_LEN = 24'd480;
  localparam logic [LEN_W-1:0]   RST_RAMP_LEN    = 24'd0;
  localparam logic [RECIP_W-1:0] RST_RAMP_RECIP  = 17'd0;
  localparam logic [LEVEL_W-1:0] RST_BURST_LEVEL = 15'd16384;
  localparam logic [LEVEL_W-1:0] RST_QUIET_LEVEL = 15'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PHASE_STEP  = 3'd0,
    CFG_PRE_LEN     = 3'd1,
    CFG_BURST_LEN   = 3'd2,
    CFG_SILENCE_LEN = 3'd3,
    CFG_RAMP_LEN    = 3'd4,
    CFG_RAMP_RECIP  = 3'd5,
    CFG_BURST_LEVEL = 3'd6,
    CFG_QUIET_LEVEL = 3'd7
  } tbg_cfg_e;

  typedef enum logic [1:0] {
    REGION_PRE   = 2'd0,
    REGION_BURST = 2'd1,
    REGION_QUIET = 2'd2
  } tbg_region_e;

  typedef struct packed {
    logic [31:0]        phase_step;
    logic [LEN_W-1:0]   pre_len;
    logic [LEN_W-1:0]   burst_len;
    logic [LEN_W-1:0]   silence_len;
    logic [LEN_W-1:0]   ramp_len;
    logic [RECIP_W-1:0] ramp_recip;
    logic [LEVEL_W-1:0] burst_level;
    logic [LEVEL_W-1:0] quiet_level;
  } tbg_cfg_t;

  typedef struct packed {
    logic [SINE_X_W-1:0]  sine_x;
    logic                 neg;
    logic [ENV_POS_W-1:0] env_pos;
    logic [LEVEL_W-1:0]   level;
    tbg_region_e          region;
  } tbg_job_t;

endpackage

`default_nettype wire

### sv/tbg_regs.sv
`default_nettype none

module tbg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tbg_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [tbg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output tbg_pkg::tbg_cfg_t                cfg_o
);

  tbg_pkg::tbg_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (tbg_pkg::tbg_cfg_e'(cfg_index_i))
        tbg_pkg::CFG_PHASE_STEP:  cfg_d.phase_step  = cfg_data_i[31:0];
        tbg_pkg::CFG_PRE_LEN:     cfg_d.pre_len     = cfg_data_i[tbg_pkg::LEN_W-1:0];
        tbg_pkg::CFG_BURST_LEN:   cfg_d.burst_len   = cfg_data_i[tbg_pkg::LEN_W-1:0];
        tbg_pkg::CFG_SILENCE_LEN: cfg_d.silence_len = cfg_data_i[tbg_pkg::LEN_W-1:0];
        tbg_pkg::CFG_RAMP_LEN:    cfg_d.ramp_len    = cfg_data_i[tbg_pkg::LEN_W-1:0];
        tbg_pkg::CFG_RAMP_RECIP:  cfg_d.ramp_recip  = cfg_data_i[tbg_pkg::RECIP_W-1:0];
        tbg_pkg::CFG_BURST_LEVEL: cfg_d.burst_level = cfg_data_i[tbg_pkg::LEVEL_W-1:0];
        tbg_pkg::CFG_QUIET_LEVEL: cfg_d.quiet_level = cfg_data_i[tbg_pkg::LEVEL_W-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step  <= tbg_pkg::RST_PHASE_STEP;
      cfg_q.pre_len     <= tbg_pkg::RST_PRE_LEN;
      cfg_q.burst_len   <= tbg_pkg::RST_BURST_LEN;
      cfg_q.silence_len <= tbg_pkg::RST_SILENCE_LEN;
      cfg_q.ramp_len    <= tbg_pkg::RST_RAMP_LEN;
      cfg_q.ramp_recip  <= tbg_pkg::RST_RAMP_RECIP;
      cfg_q.burst_level <= tbg_pkg::RST_BURST_LEVEL;
      cfg_q.quiet_level <= tbg_pkg::RST_QUIET_LEVEL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### sv/tbg_fifo.sv
`default_nettype none

module tbg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FULL);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### sv/tbg_front.sv
`default_nettype none

module tbg_front #(
  parameter int PHASE_BITS    = 32,
  parameter int LUT_ADDR_BITS = 10,
  parameter int COUNT_BITS    = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              restart_i,
  input  tbg_pkg::tbg_cfg_t cfg_i,
  input  logic              q_full_i,
  output logic              push_o,
  output tbg_pkg::tbg_job_t job_o
);

  localparam int L      = LUT_ADDR_BITS;
  localparam int CB     = COUNT_BITS;
  localparam int XSHIFT = tbg_pkg::SINE_SPAN - L;
  localparam logic [L-2:0] QUARTER = {1'b1, {(L - 2){1'b0}}};

  typedef enum logic [1:0] {
    F_IDLE     = 2'b01,
    F_CLASSIFY = 2'b10
  } tbg_front_state_e;

  tbg_front_state_e state_q, state_d;

  logic [PHASE_BITS-1:0]     phase_q, phase_d;
  logic [CB-1:0]             lead_q, lead_d;
  logic [CB:0]               cpos_q, cpos_d;
  logic [CB:0]               pos_q, pos_d;
  logic [CB:0]               cyc_q, cyc_d;
  logic                      pre_q, pre_d;
  logic                      neg_q, neg_d;
  logic [tbg_pkg::SINE_X_W-1:0] x_q, x_d;

  logic                      accept;
  logic [PHASE_BITS-1:0]     pa;
  logic [CB-1:0]             lc;
  logic [CB:0]               cp;
  logic [CB-1:0]             pre_len, blen, slen;
  logic [CB:0]               cycle;
  logic [L-1:0]              addr;
  logic [1:0]                quad;
  logic [L-2:0]              idx;
  logic [CB:0]               pos_inc, epos;
  logic                      in_burst;

  assign accept     = (state_q == F_IDLE) && in_valid_i && !q_full_i;
  assign in_stall_o = (state_q != F_IDLE) || q_full_i;
  assign push_o     = (state_q == F_CLASSIFY);

  assign pa      = restart_i ? '0 : phase_q;
  assign lc      = restart_i ? '0 : lead_q;
  assign cp      = restart_i ? '0 : cpos_q;
  assign pre_len = CB'(cfg_i.pre_len);
  assign blen    = CB'(cfg_i.burst_len);
  assign slen    = CB'(cfg_i.silence_len);
  assign cycle   = {1'b0, blen} + {1'b0, slen};

  // sine argument from the top address bits, folded to the first quadrant
  assign addr = pa[PHASE_BITS-1 -: L];
  assign quad = addr[L-1 -: 2];
  assign idx  = quad[0] ? (QUARTER - {1'b0, addr[L-3:0]}) : {1'b0, addr[L-3:0]};

  assign in_burst = (pos_q < {1'b0, blen});
  assign epos     = in_burst ? pos_q : (pos_q - {1'b0, blen});
  assign pos_inc  = pos_q + 1'b1;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    lead_d  = lead_q;
    cpos_d  = cpos_q;
    pos_d   = pos_q;
    cyc_d   = cyc_q;
    pre_d   = pre_q;
    neg_d   = neg_q;
    x_d     = x_q;
    job_o   = '0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          phase_d = pa + PHASE_BITS'(cfg_i.phase_step);
          x_d     = tbg_pkg::SINE_X_W'(idx) << XSHIFT;
          neg_d   = quad[1];
          cyc_d   = cycle;
          pos_d   = (cp < cycle) ? cp : '0;
          cpos_d  = cp;
          pre_d   = (lc < pre_len);
          lead_d  = (lc < pre_len) ? lc + 1'b1 : lc;
          state_d = F_CLASSIFY;
        end
      end
      F_CLASSIFY: begin
        job_o.sine_x = x_q;
        job_o.neg    = neg_q;
        if (pre_q) begin
          job_o.region = tbg_pkg::REGION_PRE;
        end else if (cyc_q == '0) begin
          job_o.region = tbg_pkg::REGION_QUIET;
          cpos_d       = '0;
        end else begin
          job_o.env_pos = tbg_pkg::ENV_POS_W'(epos);
          if (in_burst) begin
            job_o.region = tbg_pkg::REGION_BURST;
            job_o.level  = cfg_i.burst_level;
          end else begin
            job_o.region = tbg_pkg::REGION_QUIET;
            job_o.level  = cfg_i.quiet_level;
          end
          cpos_d = (pos_inc >= cyc_q) ? '0 : pos_inc;
        end
        state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      phase_q <= '0;
      lead_q  <= '0;
      cpos_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      lead_q  <= lead_d;
      cpos_q  <= cpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cyc_q <= cyc_d;
    pre_q <= pre_d;
    neg_q <= neg_d;
    x_q   <= x_d;
  end

endmodule

`default_nettype wire

### sv/tbg_back.sv
`default_nettype none

module tbg_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  tbg_pkg::tbg_job_t      job_i,
  output logic                   job_pop_o,
  input  tbg_pkg::tbg_cfg_t      cfg_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] sample_o,
  output logic [1:0]             region_o
);

  localparam int SB     = SAMPLE_BITS;
  localparam int MAG_SH = 31 - SB;
  localparam logic [63:0]    MAG_RND  = 64'd1 << (30 - SB);
  localparam logic [SB-1:0]  MAXV     = {1'b0, {(SB - 1){1'b1}}};
  localparam logic [16:0]    ENV_ONE  = 17'h10000;
  localparam logic [14:0]    SMAG_MAX = 15'h7fff;
  localparam logic [31:0]    POLY_C0  = 32'd1686629713;
  localparam logic [31:0]    POLY_C1  = 32'd693598668;
  localparam logic [31:0]    POLY_C2  = 32'd85569306;
  localparam logic [31:0]    POLY_C3  = 32'd5026995;
  localparam logic [31:0]    POLY_C4  = 32'd172272;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_UPD  = 4'b0100,
    B_OUT  = 4'b1000
  } tbg_back_state_e;

  typedef enum logic [2:0] {
    OP_SQ     = 3'd0,
    OP_HORNER = 3'd1,
    OP_FINAL  = 3'd2,
    OP_FRAC   = 3'd3,
    OP_ENVSQ  = 3'd4,
    OP_GAIN   = 3'd5,
    OP_MAG    = 3'd6
  } tbg_op_e;

  tbg_back_state_e state_q, state_d;
  tbg_op_e         op_q, op_d;

  logic [1:0]    hcnt_q, hcnt_d;
  logic          env_mode_q, env_mode_d;
  logic          env_on_q, env_on_d;
  logic [30:0]   x_q, x_d;
  logic [30:0]   x2_q, x2_d;
  logic [31:0]   p_q, p_d;
  logic [14:0]   smag_q, smag_d;
  logic          neg_q, neg_d;
  logic [14:0]   level_q, level_d;
  tbg_pkg::tbg_region_e region_q, region_d;
  logic [23:0]   epos_q, epos_d;
  logic [31:0]   a_q, a_d, b_q, b_d;
  logic [63:0]   prod_q, prod_d;
  logic [SB-1:0] res_q, res_d;
  logic          out_valid_q, out_valid_d;
  logic [SB-1:0] sample_q, sample_d;
  tbg_pkg::tbg_region_e out_region_q, out_region_d;

  logic [31:0]   coef;
  logic [33:0]   horner;
  logic [31:0]   y;
  logic [32:0]   srnd;
  logic [14:0]   smag_new;
  logic [16:0]   frac;
  logic [30:0]   x_frac;
  logic [63:0]   erng;
  logic [16:0]   env;
  logic [32:0]   grng;
  logic [63:0]   mshift;
  logic [SB-1:0] res_mag;

  always_comb begin
    unique case (hcnt_q)
      2'd0: coef = POLY_C3;
      2'd1: coef = POLY_C2;
      2'd2: coef = POLY_C1;
      2'd3: coef = POLY_C0;
      default: coef = POLY_C0;
    endcase
  end

  assign horner   = {2'b00, coef} - prod_q[63:30];
  assign y        = prod_q[61:30];
  assign srnd     = {1'b0, y} + 33'h4000;
  assign smag_new = (srnd[32:15] > 18'(SMAG_MAX)) ? SMAG_MAX : srnd[29:15];
  assign frac     = (prod_q > 64'(ENV_ONE)) ? ENV_ONE : prod_q[16:0];
  assign x_frac   = {frac, 14'b0};
  assign erng     = prod_q + (64'd1 << 43);
  assign env      = (erng[63:44] > 20'(ENV_ONE)) ? ENV_ONE : erng[60:44];
  assign grng     = prod_q[32:0] + 33'h8000;
  assign mshift   = (prod_q + MAG_RND) >> MAG_SH;
  assign res_mag  = (mshift > 64'(MAXV)) ? MAXV : mshift[SB-1:0];

  assign job_pop_o   = (state_q == B_IDLE) && job_valid_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign region_o    = out_region_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    hcnt_d       = hcnt_q;
    env_mode_d   = env_mode_q;
    env_on_d     = env_on_q;
    x_d          = x_q;
    x2_d         = x2_q;
    p_d          = p_q;
    smag_d       = smag_q;
    neg_d        = neg_q;
    level_d      = level_q;
    region_d     = region_q;
    epos_d       = epos_q;
    a_d          = a_q;
    b_d          = b_q;
    prod_d       = prod_q;
    res_d        = res_q;
    sample_d     = sample_q;
    out_region_d = out_region_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          x_d        = job_i.sine_x;
          neg_d      = job_i.neg;
          level_d    = job_i.level;
          region_d   = job_i.region;
          epos_d     = job_i.env_pos[tbg_pkg::LEN_W-1:0];
          env_on_d   = (cfg_i.ramp_len != '0)
                       && (job_i.env_pos < tbg_pkg::ENV_POS_W'(cfg_i.ramp_len));
          a_d        = 32'(job_i.sine_x);
          b_d        = 32'(job_i.sine_x);
          p_d        = POLY_C4;
          env_mode_d = 1'b0;
          op_d       = OP_SQ;
          state_d    = B_MUL;
        end
      end
      B_MUL: begin
        prod_d  = a_q * b_q;
        state_d = B_UPD;
      end
      B_UPD: begin
        state_d = B_MUL;
        unique case (op_q)
          OP_SQ: begin
            x2_d   = prod_q[60:30];
            a_d    = 32'(prod_q[60:30]);
            b_d    = p_q;
            hcnt_d = 2'd0;
            op_d   = OP_HORNER;
          end
          OP_HORNER: begin
            p_d = horner[31:0];
            b_d = horner[31:0];
            if (hcnt_q == 2'd3) begin
              a_d  = 32'(x_q);
              op_d = OP_FINAL;
            end else begin
              a_d    = 32'(x2_q);
              hcnt_d = hcnt_q + 1'b1;
            end
          end
          OP_FINAL: begin
            if (env_mode_q) begin
              a_d  = y;
              b_d  = y;
              op_d = OP_ENVSQ;
            end else begin
              smag_d = smag_new;
              if (env_on_q) begin
                a_d  = 32'(epos_q);
                b_d  = 32'(cfg_i.ramp_recip);
                op_d = OP_FRAC;
              end else begin
                a_d  = 32'(level_q);
                b_d  = 32'(ENV_ONE);
                op_d = OP_GAIN;
              end
            end
          end
          OP_FRAC: begin
            x_d        = x_frac;
            a_d        = 32'(x_frac);
            b_d        = 32'(x_frac);
            p_d        = POLY_C4;
            env_mode_d = 1'b1;
            op_d       = OP_SQ;
          end
          OP_ENVSQ: begin
            a_d  = 32'(level_q);
            b_d  = 32'(env);
            op_d = OP_GAIN;
          end
          OP_GAIN: begin
            a_d  = 32'(grng[31:16]);
            b_d  = 32'(smag_q);
            op_d = OP_MAG;
          end
          OP_MAG: begin
            res_d   = neg_q ? ('0 - res_mag) : res_mag;
            state_d = B_OUT;
          end
          default: state_d = B_IDLE;
        endcase
      end
      B_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          sample_d     = res_q;
          out_region_d = region_q;
          state_d      = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      op_q        <= OP_SQ;
      hcnt_q      <= '0;
      env_mode_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      hcnt_q      <= hcnt_d;
      env_mode_q  <= env_mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    env_on_q     <= env_on_d;
    x_q          <= x_d;
    x2_q         <= x2_d;
    p_q          <= p_d;
    smag_q       <= smag_d;
    neg_q        <= neg_d;
    level_q      <= level_d;
    region_q     <= region_d;
    epos_q       <= epos_d;
    a_q          <= a_d;
    b_q          <= b_d;
    prod_q       <= prod_d;
    res_q        <= res_d;
    sample_q     <= sample_d;
    out_region_q <= out_region_d;
  end

endmodule

`default_nettype wire

### sv/tone_burst_generator.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o    restart_i
// out       output     out_valid_o / out_stall_i  sample_o, region_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// the front takes a beat while the queue has room, and no new one until its last job is pushed
// the back works one sample at a time, adding an envelope pass when the ramp is
// active, on its single shared 32x32 multiplier (B_MUL then B_UPD per product)
// a finished sample waits in the output register while the next one is worked
// reset clears phase, counters, queue and output valid; no clearing pass
`default_nettype none

module tone_burst_generator #(
  parameter int PHASE_BITS    = 32,
  parameter int LUT_ADDR_BITS = 10,
  parameter int SAMPLE_BITS   = 16,
  parameter int COUNT_BITS    = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [SAMPLE_BITS-1:0]          sample_o,
  output logic [1:0]                      region_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tbg_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tbg_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int JOB_W = $bits(tbg_pkg::tbg_job_t);

  tbg_pkg::tbg_cfg_t cfg;
  tbg_pkg::tbg_job_t push_job;
  logic [JOB_W-1:0]  push_data, pop_data;
  logic              push, q_full, pop, q_valid;

  assign push_data = push_job;

  tbg_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tbg_front #(
    .PHASE_BITS    (PHASE_BITS),
    .LUT_ADDR_BITS (LUT_ADDR_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .cfg_i      (cfg),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  tbg_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (tbg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_data)
  );

  tbg_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (tbg_pkg::tbg_job_t'(pop_data)),
    .job_pop_o   (pop),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o),
    .region_o    (region_o)
  );

endmodule

`default_nettype wire
